/* rtl/wies_pkg.sv */
// wies_pkg: shared types and constants of the information element search block
// holds the request and result payload structs, the register set and its codes
// no dependencies
`timescale 1ns / 1ps

package wies_pkg;

  // widths fixed by the payload fields
  localparam int BYTE_W     = 8;
  localparam int OFFSET_W   = 12;
  localparam int OUI_W      = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int COMPARE_W  = 40;

  // highest data offset that the result can carry
  localparam int OFFSET_LIMIT = 4095;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ID      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_OUI     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TYPE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SUBTYPE = 3'd4;

  // match modes
  localparam logic [1:0] MODE_ID_ONLY  = 2'd0;
  localparam logic [1:0] MODE_OUI_TYPE = 2'd1;
  localparam logic [1:0] MODE_SUBTYPE  = 2'd2;
  localparam logic [1:0] MODE_SPARE    = 2'd3;

  // register reset values: an id only search for element 221, with the 00:50:F2 type 1 target loaded
  localparam logic [1:0]        RST_MATCH_MODE = MODE_ID_ONLY;
  localparam logic [BYTE_W-1:0] RST_TARGET_ID  = 8'd221;
  localparam logic [OUI_W-1:0]  RST_TARGET_OUI = {8'h00, 8'h50, 8'hF2};
  localparam logic [BYTE_W-1:0] RST_TARGET_TYPE    = 8'h01;
  localparam logic [BYTE_W-1:0] RST_TARGET_SUBTYPE = 8'h00;

  typedef struct packed {
    logic [1:0]        match_mode;
    logic [BYTE_W-1:0] target_id;
    logic [OUI_W-1:0]  target_oui;
    logic [BYTE_W-1:0] target_type;
    logic [BYTE_W-1:0] target_subtype;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_last;
  } frame_t;

  typedef struct packed {
    logic                found;
    logic [BYTE_W-1:0]   element_length;
    logic [OFFSET_W-1:0] data_offset;
    logic                truncated;
    logic                frame_overflow;
  } result_t;

endpackage

/* rtl/wlan_info_element_search_top.sv */
// wlan_info_element_search_top: 802.11 information element search, top level
// input register, element walker, result register and the register set
// depends on wies_pkg, wies_cfg and wies_walker
//
//   port group   direction  payload              handshake
//   frame        in         wies_pkg::frame_t    frame_valid / frame_stall
//   result       out        wies_pkg::result_t   result_valid / result_stall
//   cfg          in         index + 24-bit data  cfg_write, no wait
//
// One frame byte per cycle while frame_stall is low. A byte is registered on
// entry and walked from the input register once the result register can take
// a result; on the last byte the result register loads from the walker, so
// result_valid rises in the cycle after the walker steps on the last byte.
// Reset (rst, synchronous) clears the per-frame state and loads the
// register defaults. A stalled result holds the walker; frame_stall rises
// only while a byte waits behind it.
`timescale 1ns / 1ps

module wlan_info_element_search_top #(
  parameter int HEADER_BYTES    = 12,
  parameter int MAX_FRAME_BYTES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            frame_valid,
  output logic                            frame_stall,
  input  wies_pkg::frame_t                frame,
  output logic                            result_valid,
  input  logic                            result_stall,
  output wies_pkg::result_t               result,
  input  logic                            cfg_write,
  input  logic [wies_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wies_pkg::CFG_DATA_W-1:0] cfg_data
);

  wies_pkg::cfg_t    cfg;
  wies_pkg::frame_t  frame_reg;
  logic              frame_reg_valid;
  logic              step;
  logic              result_load;
  wies_pkg::result_t result_next;

  wies_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // the held byte moves on whenever the result register can take a result
  assign step        = frame_reg_valid && (!result_valid || !result_stall);
  assign frame_stall = frame_reg_valid && result_valid && result_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_reg_valid <= 1'b0;
    end else if (!frame_stall) begin
      frame_reg_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!frame_stall && frame_valid) begin
      frame_reg <= frame;
    end
  end

  wies_walker #(
    .HEADER_BYTES    (HEADER_BYTES),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_walker (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .step        (step),
    .frame       (frame_reg),
    .result_load (result_load),
    .result      (result_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result <= result_next;
    end
  end

endmodule

/* rtl/wies_cfg.sv */
// wies_cfg: configuration register set of the information element search block
// decodes the write port into the match mode and target registers
// depends on wies_pkg
`timescale 1ns / 1ps

module wies_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [wies_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wies_pkg::CFG_DATA_W-1:0] cfg_data,
  output wies_pkg::cfg_t                  cfg
);

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_mode     <= wies_pkg::RST_MATCH_MODE;
      cfg.target_id      <= wies_pkg::RST_TARGET_ID;
      cfg.target_oui     <= wies_pkg::RST_TARGET_OUI;
      cfg.target_type    <= wies_pkg::RST_TARGET_TYPE;
      cfg.target_subtype <= wies_pkg::RST_TARGET_SUBTYPE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wies_pkg::CFG_MATCH_MODE:     cfg.match_mode     <= cfg_data[1:0];
        wies_pkg::CFG_TARGET_ID:      cfg.target_id      <= cfg_data[7:0];
        wies_pkg::CFG_TARGET_OUI:     cfg.target_oui     <= cfg_data[23:0];
        wies_pkg::CFG_TARGET_TYPE:    cfg.target_type    <= cfg_data[7:0];
        wies_pkg::CFG_TARGET_SUBTYPE: cfg.target_subtype <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/wies_walker.sv */
// wies_walker: per-byte element walk and match logic with the per-frame state
// takes one registered frame byte per step and forms the result on the last byte
// depends on wies_pkg
`timescale 1ns / 1ps

module wies_walker #(
  parameter int HEADER_BYTES    = 12,
  parameter int MAX_FRAME_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  wies_pkg::cfg_t      cfg,
  input  logic                step,
  input  wies_pkg::frame_t    frame,
  output logic                result_load,
  output wies_pkg::result_t   result
);

  // positions reach the frame limit plus one maximal element
  localparam int CW = $clog2(MAX_FRAME_BYTES + 257);

  logic [CW-1:0]                     pos, pos_next;
  logic [CW-1:0]                     nes, nes_next;
  logic [CW-1:0]                     match_end, match_end_next;
  logic [wies_pkg::BYTE_W-1:0]       id_held, id_held_next;
  logic [wies_pkg::BYTE_W-1:0]       len_held, len_held_next;
  logic [wies_pkg::BYTE_W-1:0]       match_len, match_len_next;
  logic [wies_pkg::OFFSET_W-1:0]     match_off, match_off_next;
  logic [wies_pkg::COMPARE_W-1:0]    cmp, cmp_next;
  logic                              done, done_next;
  logic                              ovf, ovf_next;

  logic [CW-1:0] elem_start;
  logic [CW-1:0] data_idx;
  logic [CW-1:0] len_pos;
  logic          mode_full;

  assign elem_start = nes - CW'(len_held);
  assign data_idx   = pos - elem_start;
  assign len_pos    = nes + CW'(1);
  assign mode_full  = (cfg.match_mode == wies_pkg::MODE_SUBTYPE) ||
                      (cfg.match_mode == wies_pkg::MODE_SPARE);

  // walk one byte and build the end of frame result
  always_comb begin
    pos_next       = pos;
    nes_next       = nes;
    match_end_next = match_end;
    id_held_next   = id_held;
    len_held_next  = len_held;
    match_len_next = match_len;
    match_off_next = match_off;
    cmp_next       = cmp;
    done_next      = done;
    ovf_next       = ovf;

    if (step) begin
      if (pos == CW'(MAX_FRAME_BYTES)) begin
        ovf_next = 1'b1;
      end else begin
        pos_next = pos + CW'(1);
        if (!done && pos >= CW'(HEADER_BYTES)) begin
          if (pos == nes) begin
            // element id byte
            id_held_next = frame.frame_byte;
          end else if (pos == len_pos) begin
            // length byte: set the next element start, id only match here
            len_held_next = frame.frame_byte;
            nes_next      = pos + CW'(1) + CW'(frame.frame_byte);
            if (cfg.match_mode == wies_pkg::MODE_ID_ONLY && id_held == cfg.target_id &&
                32'(pos) < 32'(wies_pkg::OFFSET_LIMIT)) begin
              done_next      = 1'b1;
              match_len_next = frame.frame_byte;
              match_off_next = wies_pkg::OFFSET_W'(pos + CW'(1));
              match_end_next = pos + CW'(1) + CW'(frame.frame_byte);
            end
          end else if (pos >= elem_start && pos < nes && data_idx < CW'(5)) begin
            // leading data bytes go through the compare window
            if (data_idx == '0) begin
              cmp_next = wies_pkg::COMPARE_W'(frame.frame_byte);
            end else begin
              cmp_next = {cmp[31:0], frame.frame_byte};
            end
            if (id_held == cfg.target_id &&
                32'(elem_start) <= 32'(wies_pkg::OFFSET_LIMIT)) begin
              if (cfg.match_mode == wies_pkg::MODE_OUI_TYPE && data_idx == CW'(3) &&
                  cmp_next[31:0] == {cfg.target_oui, cfg.target_type}) begin
                done_next      = 1'b1;
                match_len_next = len_held;
                match_off_next = wies_pkg::OFFSET_W'(elem_start);
                match_end_next = nes;
              end else if (mode_full && data_idx == CW'(4) &&
                           cmp_next == {cfg.target_oui, cfg.target_type,
                                        cfg.target_subtype}) begin
                done_next      = 1'b1;
                match_len_next = len_held;
                match_off_next = wies_pkg::OFFSET_W'(elem_start);
                match_end_next = nes;
              end
            end
          end
        end
      end
    end

    // result from the state after this byte
    result_load           = step && frame.frame_last;
    result.found          = done_next;
    result.element_length = done_next ? match_len_next : '0;
    result.data_offset    = done_next ? match_off_next : '0;
    result.truncated      = done_next && (match_end_next > pos_next);
    result.frame_overflow = ovf_next;
  end

  // per-frame state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst || result_load) begin
      pos       <= '0;
      nes       <= CW'(HEADER_BYTES);
      match_end <= '0;
      id_held   <= '0;
      len_held  <= '0;
      match_len <= '0;
      match_off <= '0;
      cmp       <= '0;
      done      <= 1'b0;
      ovf       <= 1'b0;
    end else begin
      pos       <= pos_next;
      nes       <= nes_next;
      match_end <= match_end_next;
      id_held   <= id_held_next;
      len_held  <= len_held_next;
      match_len <= match_len_next;
      match_off <= match_off_next;
      cmp       <= cmp_next;
      done      <= done_next;
      ovf       <= ovf_next;
    end
  end

endmodule
